>>> hw/rtl/dpb_pkg.sv
package dpb_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int CNT_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = 13;
    localparam int DIFF_W      = 13;
    localparam int DEPTH_W     = 16;
    localparam int COLOR_W     = 8;
    localparam int INV_W       = 24;
    localparam int COORD_W     = 32;
    localparam int SHIFT_BITS  = 21;
    localparam int PROD_W      = DIFF_W + DEPTH_W;
    localparam int MAG_W       = PROD_W + INV_W;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 104;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_INV_FOCAL_X   = 3'd2,
        REG_INV_FOCAL_Y   = 3'd3,
        REG_CENTER_X_HALF = 3'd4,
        REG_CENTER_Y_HALF = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [INV_W-1:0] inv_focal_x;
        logic [INV_W-1:0] inv_focal_y;
        logic [DIM_W-1:0] center_x_half;
        logic [DIM_W-1:0] center_y_half;
    } cfg_t;

    // pixel as classified by the front end, waiting for the multipliers
    typedef struct packed {
        logic                neg_x;
        logic [DIFF_W-1:0]   diff_x;
        logic                neg_y;
        logic [DIFF_W-1:0]   diff_y;
        logic [DEPTH_W-1:0]  depth;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic                frame_end;
    } entry_t;

    // fields that ride along the multiplier stages
    typedef struct packed {
        logic                neg_x;
        logic                neg_y;
        logic [DEPTH_W-1:0]  depth;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic                frame_end;
    } meta_t;

    // index of the last column (row) for a programmed size, clamped to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] dim_last(logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = '0;
        end
        else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM - 1);
        end
        else begin
            r = v - DIM_W'(1);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/dpb_front.sv
module dpb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dpb_pkg::cfg_t                 cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dpb_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          fifo_full,
    output logic                          push,
    output dpb_pkg::entry_t               push_entry
);
    import dpb_pkg::*;

    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] row_next;
    logic [DIM_W-1:0] col_last;
    logic [DIM_W-1:0] row_last;
    logic             last_col;
    logic             last_row;
    logic [DIM_W-1:0] twice_col;
    logic [DIM_W-1:0] twice_row;

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && s_tready;

    assign col_last = dim_last(cfg.frame_width);
    assign row_last = dim_last(cfg.frame_height);
    assign last_col = {1'b0, col_reg} >= col_last;
    assign last_row = {1'b0, row_reg} >= row_last;

    assign twice_col = {col_reg, 1'b0};
    assign twice_row = {row_reg, 1'b0};

    always_comb
    begin
        push_entry.neg_x  = twice_col < cfg.center_x_half;
        push_entry.diff_x = push_entry.neg_x ? (cfg.center_x_half - twice_col)
                                             : (twice_col - cfg.center_x_half);
        push_entry.neg_y  = twice_row < cfg.center_y_half;
        push_entry.diff_y = push_entry.neg_y ? (cfg.center_y_half - twice_row)
                                             : (twice_row - cfg.center_y_half);
        push_entry.depth     = s_tdata[15:0];
        push_entry.red       = s_tdata[23:16];
        push_entry.green     = s_tdata[31:24];
        push_entry.blue      = s_tdata[39:32];
        push_entry.frame_end = last_col && last_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (push) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + CNT_W'(1);
            end
            else begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> hw/rtl/dpb_fifo.sv
module dpb_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dpb_pkg::entry_t push_entry,
    input  logic            pop,
    output dpb_pkg::entry_t pop_entry,
    output logic            full,
    output logic            empty
);
    import dpb_pkg::*;

    entry_t             slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    assign full      = count_reg == FIFO_CW'(FIFO_DEPTH);
    assign empty     = count_reg == '0;
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + FIFO_CW'(1);
        end
        else if (pop && !push) begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hw/rtl/dpb_back.sv
module dpb_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dpb_pkg::cfg_t                  cfg,
    input  dpb_pkg::entry_t                pop_entry,
    input  logic                           fifo_empty,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dpb_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import dpb_pkg::*;

    localparam int Q_W = MAG_W - SHIFT_BITS + 1;

    logic                   en;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   out_valid_reg;
    logic [PROD_W-1:0]      prod_x_reg;
    logic [PROD_W-1:0]      prod_y_reg;
    meta_t                  meta1_reg;
    logic [MAG_W-1:0]       mag_x_reg;
    logic [MAG_W-1:0]       mag_y_reg;
    meta_t                  meta2_reg;
    logic [OUT_DATA_W-1:0]  data_reg;
    logic                   valid_pt_reg;
    logic                   last_reg;
    meta_t                  meta0;

    // floor of (+/-mag) / 2^21, sign applied before rounding, saturated to signed 32 bits
    function automatic logic [COORD_W-1:0] scale(logic [MAG_W-1:0] mag, logic neg);
        logic [MAG_W:0]       up;
        logic [Q_W-1:0]       q;
        logic [COORD_W-1:0]   r;
        if (!neg) begin
            q = {1'b0, mag[MAG_W-1:SHIFT_BITS]};
            r = (q > Q_W'(64'h7FFF_FFFF)) ? COORD_W'(64'h7FFF_FFFF) : q[COORD_W-1:0];
        end
        else begin
            up = {1'b0, mag} + (MAG_W+1)'((64'd1 << SHIFT_BITS) - 64'd1);
            q  = up[MAG_W:SHIFT_BITS];
            r  = (q > Q_W'(64'h8000_0000)) ? COORD_W'(64'h8000_0000)
                                           : (~q[COORD_W-1:0] + COORD_W'(1));
        end
        return r;
    endfunction

    // whole pipeline moves together whenever the output slot can take a result
    assign en  = !out_valid_reg || m_tready;
    assign pop = en && !fifo_empty;

    always_comb
    begin
        meta0.neg_x     = pop_entry.neg_x;
        meta0.neg_y     = pop_entry.neg_y;
        meta0.depth     = pop_entry.depth;
        meta0.red       = pop_entry.red;
        meta0.green     = pop_entry.green;
        meta0.blue      = pop_entry.blue;
        meta0.frame_end = pop_entry.frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            v1_reg        <= pop;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            prod_x_reg <= PROD_W'(pop_entry.diff_x) * PROD_W'(pop_entry.depth);
            prod_y_reg <= PROD_W'(pop_entry.diff_y) * PROD_W'(pop_entry.depth);
            meta1_reg  <= meta0;
            mag_x_reg  <= MAG_W'(prod_x_reg) * MAG_W'(cfg.inv_focal_x);
            mag_y_reg  <= MAG_W'(prod_y_reg) * MAG_W'(cfg.inv_focal_y);
            meta2_reg  <= meta1_reg;
            data_reg   <= {meta2_reg.blue, meta2_reg.green, meta2_reg.red,
                           meta2_reg.depth,
                           scale(mag_y_reg, meta2_reg.neg_y),
                           scale(mag_x_reg, meta2_reg.neg_x)};
            valid_pt_reg <= meta2_reg.depth != '0;
            last_reg     <= meta2_reg.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = valid_pt_reg;
    assign m_tlast  = last_reg;

endmodule

>>> hw/rtl/depth_pixel_backprojection.sv
// on its way out a pixel passes the queue, the two multiplier stages and the output slot
// throughput: one pixel per cycle while m_tready does not stall the output slot
// a 4-entry queue between front end and multipliers absorbs short output stalls
// reset: configuration returns to 640x480 defaults, column and row counters clear,
//   queue and pipeline empty; no clearing pass, the block is ready right after reset
module depth_pixel_backprojection (
    input  logic                           clk,
    input  logic                           rst_n,
    // pixel stream in
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dpb_pkg::IN_DATA_W-1:0]  s_tdata,   // depth_mm, red_in, green_in, blue_in
    // point stream out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dpb_pkg::OUT_DATA_W-1:0] m_tdata,   // x_pos, y_pos, z_pos, red_out,
                                                      // green_out, blue_out
    output logic                           m_tuser,   // point_valid
    output logic                           m_tlast,   // frame_end
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dpb_pkg::*;

    cfg_t   cfg_reg;
    logic   fifo_full;
    logic   fifo_empty;
    logic   push;
    logic   pop;
    entry_t push_entry;
    entry_t pop_entry;

    // register writes are always accepted, so the port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.frame_width   <= DIM_W'(640);
            cfg_reg.frame_height  <= DIM_W'(480);
            cfg_reg.inv_focal_x   <= INV_W'(31957);
            cfg_reg.inv_focal_y   <= INV_W'(31957);
            cfg_reg.center_x_half <= DIM_W'(639);
            cfg_reg.center_y_half <= DIM_W'(479);
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_WIDTH:   cfg_reg.frame_width   <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= cfg_data[DIM_W-1:0];
                REG_INV_FOCAL_X:   cfg_reg.inv_focal_x   <= cfg_data[INV_W-1:0];
                REG_INV_FOCAL_Y:   cfg_reg.inv_focal_y   <= cfg_data[INV_W-1:0];
                REG_CENTER_X_HALF: cfg_reg.center_x_half <= cfg_data[DIM_W-1:0];
                REG_CENTER_Y_HALF: cfg_reg.center_y_half <= cfg_data[DIM_W-1:0];
                default:           ;  // unknown index, write dropped
            endcase
        end
    end

    // front end: raster counters, offset from principal point, frame end
    dpb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // short queue so the front end keeps taking pixels while the output stalls
    dpb_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (fifo_full),
        .empty      (fifo_empty)
    );

    // back end: offset * depth, then * inverse focal, then shift and saturate
    dpb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop_entry  (pop_entry),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // a missing reading must come out as an all-zero point
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[79:0] == '0)
        else $error("invalid point with nonzero coordinates");

    // a valid point always carries a nonzero depth
    a_valid_depth: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[79:64] != '0)
        else $error("valid point with zero depth");

    // the front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_full)
        else $error("pixel pushed into full queue");

endmodule
